[src/assert_macros.svh]
// Assertion macros for the RTL files; only the calculator top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CHECK_IMPLY(label, clk, rst, ante, cons)
`define CHECK_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/pwmc_pkg.sv]
// Shared widths, codes and tables for the PWM period/duty calculator.
package pwmc_pkg;

  localparam int CLK_W   = 29;
  localparam int FREQ_W  = 16;
  localparam int DUTY_W  = 17;
  localparam int DEV_W   = 3;
  localparam int CHAN_W  = 3;
  localparam int ACT_W   = 3;
  localparam int PRE_W   = 3;
  localparam int TOP_W   = 25;
  localparam int CMP_W   = 25;
  localparam int BTOP_W  = 17;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int DUTY_FRACTION_BITS  = 16;
  localparam int PRESCALER_STEPS     = 8;
  localparam int BASIC_TIMERS_DEF    = 6;
  localparam int ADVANCED_TIMERS_DEF = 5;

  // counter widths: basic timers are 16 bit, the first advanced timers 24 bit
  localparam int NARROW_BITS     = 16;
  localparam int WIDE_BITS       = 24;
  localparam int ADV_WIDE_TIMERS = 2;

  localparam logic [CLK_W-1:0]  CLK_RESET     = 29'd120000000;
  localparam logic [CLK_W-1:0]  BASIC_OUT0_Q  = 29'h10000;  // top 0xFFFF plus one
  localparam logic [DUTY_W-1:0] DUTY_ONE      = DUTY_W'(1 << DUTY_FRACTION_BITS);
  localparam logic [DUTY_W-1:0] DUTY_HALF     = DUTY_W'(1 << (DUTY_FRACTION_BITS - 1));
  localparam logic [PRE_W-1:0]  PRE_FALLBACK  = PRE_W'(PRESCALER_STEPS - 1);

  // register map (index bit of paddr)
  localparam logic REG_PERIPH_CLOCK = 1'b0;

  // result actions
  localparam logic [ACT_W-1:0] ACT_LOW        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HIGH       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BASIC_PROG = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BASIC_CMP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ADV_PROG   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ADV_CMP    = 3'd5;

  // prescaler shift table
  function automatic int unsigned presc_shift(input logic [PRE_W-1:0] idx);
    int unsigned sh;
    case (idx)
      3'd0:    sh = 0;
      3'd1:    sh = 1;
      3'd2:    sh = 2;
      3'd3:    sh = 3;
      3'd4:    sh = 4;
      3'd5:    sh = 6;
      3'd6:    sh = 8;
      3'd7:    sh = 10;
      default: sh = 0;
    endcase
    return sh;
  endfunction

endpackage

[src/pwmc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module pwmc_div import pwmc_pkg::*; #(
  parameter int DIVIDEND_W = CLK_W,
  parameter int DIVISOR_W  = FREQ_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 running;
  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 take;

  // dividend bits leave the top of the quotient register as quotient bits enter
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(DIVIDEND_W);
      end else if (running) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      rem      <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], take};
    end
  end

endmodule

[src/pwmc_mul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
module pwmc_mul import pwmc_pkg::*; #(
  parameter int A_W = TOP_W + 1,
  parameter int B_W = DUTY_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [A_W-1:0]   mcand;
  logic [A_W:0]     sum;

  // upper half accumulates, lower half holds the multiplier bits not yet used
  assign sum = {1'b0, product[P_W-1:B_W]} + (product[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(B_W);
      end else if (running) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= {A_W'(0), b};
      mcand   <= a;
    end else if (running) begin
      product <= {sum, product[B_W-1:1]};
    end
  end

endmodule

[src/pwm_period_duty_calculator.sv]
// PWM period/duty calculator: takes one request word at a time and returns one result word.
// A request that reprograms a timer through the divider steps through the prescaler search,
// the 29-step bit-serial divider for the period quotient, the top update, then the 17-step
// shift-add multiplier for the compare value and rounding before its result word is loaded.
// A reprogram whose top needs no division (basic output 0, or no prescaler fits) skips the
// divider. A compare-only request (frequency equal to the cached one) goes straight to the
// multiplier. A digital result goes straight to the output step. The next request is
// accepted once the previous result sits in the output register, even if that word is still
// stalled. A result that finds the previous word still stalled waits in its last step and
// holds off the following request. peripheral_clock is written over the APB port; write it
// only while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"

module pwm_period_duty_calculator import pwmc_pkg::*; #(
  parameter int BASIC_TIMERS    = BASIC_TIMERS_DEF,
  parameter int ADVANCED_TIMERS = ADVANCED_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              has_basic,
  input  logic [DEV_W-1:0]  basic_device,
  input  logic              basic_output,
  input  logic              has_advanced,
  input  logic [DEV_W-1:0]  advanced_device,
  input  logic [CHAN_W-1:0] advanced_output,
  input  logic [DUTY_W-1:0] duty,
  input  logic [FREQ_W-1:0] freq,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ACT_W-1:0]  action,
  output logic [DEV_W-1:0]  device_number,
  output logic [CHAN_W-1:0] output_number,
  output logic [PRE_W-1:0]  prescaler_index,
  output logic [TOP_W-1:0]  period_top,
  output logic [CMP_W-1:0]  compare,
  output logic              needs_init
);

  localparam int BIW     = (BASIC_TIMERS > 1) ? $clog2(BASIC_TIMERS) : 1;
  localparam int AIW     = (ADVANCED_TIMERS > 1) ? $clog2(ADVANCED_TIMERS) : 1;
  localparam int MUL_A_W = TOP_W + 1;
  localparam int MUL_P_W = MUL_A_W + DUTY_W;
  localparam int MQ_W    = MUL_P_W - DUTY_FRACTION_BITS;
  localparam int CS_W    = CLK_W - NARROW_BITS;

  localparam logic [DEV_W:0]   BASIC_LIMIT = BASIC_TIMERS[DEV_W:0];
  localparam logic [DEV_W:0]   ADV_LIMIT   = ADVANCED_TIMERS[DEV_W:0];
  localparam logic [DEV_W-1:0] WIDE_LIMIT  = ADV_WIDE_TIMERS[DEV_W-1:0];
  localparam logic [DUTY_FRACTION_BITS-1:0] FRAC_HALF =
    DUTY_FRACTION_BITS'(1 << (DUTY_FRACTION_BITS - 1));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_PRESC  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_TOP    = 4'd4;
  localparam logic [3:0] S_MSTART = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_RND    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]       state;
  logic [CLK_W-1:0] peripheral_clock;

  // latched request
  logic              req_has_basic;
  logic [DEV_W-1:0]  req_basic_device;
  logic              req_basic_output;
  logic              req_has_advanced;
  logic [DEV_W-1:0]  req_advanced_device;
  logic [CHAN_W-1:0] req_advanced_output;
  logic [DUTY_W-1:0] req_duty;
  logic [FREQ_W-1:0] req_freq;

  // working result
  logic              wk_adv;
  logic              wk_wide;
  logic [DEV_W-1:0]  wk_dev;
  logic [CHAN_W-1:0] wk_chan;
  logic [ACT_W-1:0]  wk_action;
  logic [PRE_W-1:0]  wk_pre;
  logic [TOP_W-1:0]  wk_top;
  logic [CMP_W-1:0]  wk_cmp;
  logic              wk_init;
  logic [CLK_W-1:0]  wk_quot;

  // per-timer caches
  logic [FREQ_W-1:0] basic_freq_cache    [BASIC_TIMERS];
  logic [BTOP_W-1:0] basic_top_cache     [BASIC_TIMERS];
  logic [FREQ_W-1:0] advanced_freq_cache [ADVANCED_TIMERS];
  logic [TOP_W-1:0]  advanced_top_cache  [ADVANCED_TIMERS];

  logic              in_accept;
  logic              out_free;
  logic              pwm;
  logic              freq_zero;
  logic              b_ok;
  logic              a_ok;
  logic [BIW-1:0]    bidx;
  logic [AIW-1:0]    aidx;
  logic [BIW-1:0]    wbidx;
  logic [AIW-1:0]    waidx;
  logic [FREQ_W-1:0] bf;
  logic [FREQ_W-1:0] af;
  logic              digital_lvl;

  logic [CS_W-1:0]   csel;
  logic              fit_any;
  logic [PRE_W-1:0]  pick;
  logic [CLK_W-1:0]  dividend;
  logic              force_b0;
  logic              skip_div;

  logic [CLK_W-1:0]  tq;
  logic [TOP_W-1:0]  top_new;

  logic              div_start;
  logic              div_done;
  logic [CLK_W-1:0]  div_q;
  logic              mul_start;
  logic              mul_done;
  logic [MUL_P_W-1:0] mul_p;
  logic [MUL_A_W-1:0] mul_a;

  logic [MQ_W-1:0]   mq;
  logic [DUTY_FRACTION_BITS-1:0] mr;
  logic              rnd_up;
  logic [CMP_W-1:0]  cmp_v;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_PERIPH_CLOCK) ? DATA_W'(peripheral_clock) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      peripheral_clock <= CLK_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1] == REG_PERIPH_CLOCK)) begin
      peripheral_clock <= pwdata[CLK_W-1:0];
    end
  end

  // ---------------- request decode ----------------
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign pwm         = (req_duty != '0) && (req_duty < DUTY_ONE);
  assign freq_zero   = (req_freq == '0);
  assign b_ok        = req_has_basic && ({1'b0, req_basic_device} < BASIC_LIMIT);
  assign a_ok        = req_has_advanced && ({1'b0, req_advanced_device} < ADV_LIMIT);
  assign bidx        = req_basic_device[BIW-1:0];
  assign aidx        = req_advanced_device[AIW-1:0];
  assign wbidx       = wk_dev[BIW-1:0];
  assign waidx       = wk_dev[AIW-1:0];
  assign bf          = basic_freq_cache[bidx];
  assign af          = advanced_freq_cache[aidx];
  assign digital_lvl = (req_duty < DUTY_HALF);

  // ---------------- prescaler search ----------------
  // clock >> (shift + bits) <= freq, with the counter-width shift taken first
  assign csel = wk_wide ? CS_W'(peripheral_clock[CLK_W-1:WIDE_BITS])
                        : peripheral_clock[CLK_W-1:NARROW_BITS];

  always_comb begin
    fit_any = 1'b0;
    pick    = PRE_FALLBACK;
    for (int i = PRESCALER_STEPS - 1; i >= 0; i--) begin
      if (FREQ_W'(csel >> presc_shift(PRE_W'(i))) <= req_freq) begin
        fit_any = 1'b1;
        pick    = PRE_W'(i);
      end
    end
  end

  assign dividend = peripheral_clock >> presc_shift(pick);
  assign force_b0 = !wk_adv && (wk_chan == '0);
  assign skip_div = force_b0 || !fit_any;
  assign div_start = (state == S_PRESC) && !skip_div;

  pwmc_div #(
    .DIVIDEND_W (CLK_W),
    .DIVISOR_W  (FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (req_freq),
    .done     (div_done),
    .quotient (div_q)
  );

  // top = quotient - 1, held at zero for a zero quotient
  assign tq      = (wk_quot == '0) ? '0 : wk_quot - CLK_W'(1);
  assign top_new = wk_adv ? tq[TOP_W-1:0] : TOP_W'(tq[BTOP_W-1:0]);

  // ---------------- compare value ----------------
  assign mul_start = (state == S_MSTART);
  assign mul_a     = {1'b0, wk_top} + MUL_A_W'(1);

  pwmc_mul #(
    .A_W (MUL_A_W),
    .B_W (DUTY_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (req_duty),
    .done    (mul_done),
    .product (mul_p)
  );

  // round half to even
  assign mq     = mul_p[MUL_P_W-1:DUTY_FRACTION_BITS];
  assign mr     = mul_p[DUTY_FRACTION_BITS-1:0];
  assign rnd_up = (mr > FRAC_HALF) || ((mr == FRAC_HALF) && mq[0]);
  assign cmp_v  = mq[CMP_W-1:0] + CMP_W'(rnd_up);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (pwm && !freq_zero && b_ok) begin
            state <= (req_freq != bf) ? S_PRESC : S_MSTART;
          end else if (pwm && !freq_zero && a_ok) begin
            state <= (req_freq != af) ? S_PRESC : S_MSTART;
          end else begin
            state <= S_DONE;
          end
        end
        S_PRESC:  state <= skip_div ? S_TOP : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_TOP;
          end
        end
        S_TOP:    state <= S_MSTART;
        S_MSTART: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            state <= S_RND;
          end
        end
        S_RND:    state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // ---------------- working and output registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          req_has_basic       <= has_basic;
          req_basic_device    <= basic_device;
          req_basic_output    <= basic_output;
          req_has_advanced    <= has_advanced;
          req_advanced_device <= advanced_device;
          req_advanced_output <= advanced_output;
          req_duty            <= duty;
          req_freq            <= freq;
        end
      end
      S_DECIDE: begin
        wk_pre  <= '0;
        wk_cmp  <= '0;
        if (pwm && !freq_zero && b_ok) begin
          wk_adv  <= 1'b0;
          wk_wide <= 1'b0;
          wk_dev  <= req_basic_device;
          wk_chan <= CHAN_W'(req_basic_output);
          if (req_freq != bf) begin
            wk_action <= ACT_BASIC_PROG;
            wk_init   <= (bf == '0);
          end else begin
            wk_action <= ACT_BASIC_CMP;
            wk_init   <= 1'b0;
            wk_top    <= TOP_W'(basic_top_cache[bidx]);
          end
        end else if (pwm && !freq_zero && a_ok) begin
          wk_adv  <= 1'b1;
          wk_wide <= (req_advanced_device < WIDE_LIMIT);
          wk_dev  <= req_advanced_device;
          wk_chan <= req_advanced_output;
          if (req_freq != af) begin
            wk_action <= ACT_ADV_PROG;
            wk_init   <= (af == '0);
          end else begin
            wk_action <= ACT_ADV_CMP;
            wk_init   <= 1'b0;
            wk_top    <= advanced_top_cache[aidx];
          end
        end else begin
          wk_action <= digital_lvl ? ACT_LOW : ACT_HIGH;
          wk_init   <= 1'b0;
          wk_dev    <= '0;
          wk_chan   <= '0;
          wk_top    <= '0;
        end
      end
      S_PRESC: begin
        wk_pre <= fit_any ? pick : PRE_FALLBACK;
        if (force_b0) begin
          wk_quot <= BASIC_OUT0_Q;
        end else if (!fit_any) begin
          wk_quot <= CLK_W'(1) << (wk_wide ? WIDE_BITS : NARROW_BITS);
        end
      end
      S_DIV: begin
        if (div_done) begin
          wk_quot <= div_q;
        end
      end
      S_TOP:   wk_top <= top_new;
      S_RND:   wk_cmp <= cmp_v;
      S_DONE: begin
        if (out_free) begin
          action          <= wk_action;
          device_number   <= wk_dev;
          output_number   <= wk_chan;
          prescaler_index <= wk_pre;
          period_top      <= wk_top;
          compare         <= wk_cmp;
          needs_init      <= wk_init;
        end
      end
      default: ;
    endcase
  end

  // ---------------- timer caches ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BASIC_TIMERS; i++) begin
        basic_freq_cache[i] <= '0;
        basic_top_cache[i]  <= '0;
      end
      for (int i = 0; i < ADVANCED_TIMERS; i++) begin
        advanced_freq_cache[i] <= '0;
        advanced_top_cache[i]  <= '0;
      end
    end else begin
      if ((state == S_DECIDE) && pwm && freq_zero) begin
        // zero frequency drops the cached frequency, keeps the top
        if (b_ok) begin
          basic_freq_cache[bidx] <= '0;
        end
        if (a_ok) begin
          advanced_freq_cache[aidx] <= '0;
        end
      end
      if (state == S_TOP) begin
        if (wk_adv) begin
          advanced_top_cache[waidx]  <= top_new;
          advanced_freq_cache[waidx] <= req_freq;
        end else begin
          basic_top_cache[wbidx]  <= top_new[BTOP_W-1:0];
          basic_freq_cache[wbidx] <= req_freq;
        end
      end
    end
  end

  // ---------------- checks ----------------
  `CHECK_NEXT(a_word_load, clk, rst, (state == S_DONE) && out_free, out_valid)
  `CHECK_IMPLY(a_dig_zero, clk, rst,
    out_valid && ((action == ACT_LOW) || (action == ACT_HIGH)),
    (period_top == '0) && (compare == '0) && !needs_init)
  `CHECK_IMPLY(a_cmp_only, clk, rst,
    out_valid && ((action == ACT_BASIC_CMP) || (action == ACT_ADV_CMP)),
    (prescaler_index == '0) && !needs_init)
  `CHECK_IMPLY(a_basic_top, clk, rst,
    out_valid && ((action == ACT_BASIC_PROG) || (action == ACT_BASIC_CMP)),
    period_top[TOP_W-1:BTOP_W] == '0)

endmodule
